// File: hw/rtl/s2d_pkg.sv
// Shared types and character constants for the signed integer to decimal text converter.
`default_nettype none

package s2d_pkg;

  localparam int unsigned ValueW    = 32;
  localparam int unsigned NumDigits = 10;
  localparam int unsigned BcdW      = 4 * NumDigits;
  localparam int unsigned DigCntW   = 4;

  localparam logic [6:0] CharZero  = 7'h30;
  localparam logic [6:0] CharMinus = 7'h2D;
  localparam logic [6:0] CharPlus  = 7'h2B;

  typedef struct packed {
    logic signed [ValueW-1:0] value;
    logic [6:0]               start_position;
    logic                     plus_sign;
  } s2d_in_t;

  typedef struct packed {
    logic [6:0] char_code;
    logic [6:0] char_position;
    logic [7:0] end_position;
    logic       is_last;
  } s2d_out_t;

  // Hand-over from the converter to the character emitter.
  typedef struct packed {
    logic [BcdW-1:0] bcd;
    logic            negative;
    logic            sign_en;
    logic [6:0]      start_position;
  } s2d_work_t;

endpackage

`default_nettype wire

// File: hw/rtl/s2d_dabble.sv
// Bit-serial binary to BCD converter using shift-and-add-three, one magnitude bit per cycle.
`default_nettype none

module s2d_dabble (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire s2d_pkg::s2d_in_t   in_data_i,
  output logic                    work_valid_o,
  input  wire logic               work_ready_i,
  output s2d_pkg::s2d_work_t      work_o
);
  import s2d_pkg::*;

  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StConv = 3'b010,
    StDone = 3'b100
  } dab_state_e;

  dab_state_e state_q, state_d;
  logic [4:0]        cnt_q, cnt_d;
  logic [ValueW-1:0] mag_q, mag_d;
  logic [BcdW-1:0]   bcd_q, bcd_d, bcd_adj;
  logic              neg_q, neg_d;
  logic              sign_en_q, sign_en_d;
  logic [6:0]        start_q, start_d;
  logic              in_neg;

  assign in_neg = in_data_i.value[ValueW-1];

  // Add three to every digit of five or more before the shift.
  always_comb begin
    for (int i = 0; i < NumDigits; i++) begin
      if (bcd_q[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = bcd_q[4*i +: 4];
      end
    end
  end

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    mag_d     = mag_q;
    bcd_d     = bcd_q;
    neg_d     = neg_q;
    sign_en_d = sign_en_q;
    start_d   = start_q;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          neg_d     = in_neg;
          sign_en_d = in_neg | in_data_i.plus_sign;
          start_d   = in_data_i.start_position;
          mag_d     = in_neg ? (ValueW'(0) - ValueW'(in_data_i.value))
                             : ValueW'(in_data_i.value);
          bcd_d     = '0;
          cnt_d     = '0;
          state_d   = StConv;
        end
      end
      StConv: begin
        bcd_d = {bcd_adj[BcdW-2:0], mag_q[ValueW-1]};
        mag_d = {mag_q[ValueW-2:0], 1'b0};
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          state_d = StDone;
        end
      end
      StDone: begin
        if (work_ready_i) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q     <= mag_d;
    bcd_q     <= bcd_d;
    neg_q     <= neg_d;
    sign_en_q <= sign_en_d;
    start_q   <= start_d;
  end

  assign in_ready_o            = (state_q == StIdle);
  assign work_valid_o          = (state_q == StDone);
  assign work_o.bcd            = bcd_q;
  assign work_o.negative       = neg_q;
  assign work_o.sign_en        = sign_en_q;
  assign work_o.start_position = start_q;

endmodule

`default_nettype wire

// File: hw/rtl/s2d_emit.sv
// Character emitter: strips leading zero digits, then sends sign and digits one per beat.
`default_nettype none

module s2d_emit #(
  parameter int unsigned BUFFER_LENGTH = 128
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                work_valid_i,
  output logic                     work_ready_o,
  input  wire s2d_pkg::s2d_work_t  work_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output s2d_pkg::s2d_out_t        out_o
);
  import s2d_pkg::*;

  localparam int unsigned PosW =
      ($clog2(BUFFER_LENGTH + 1) > 8) ? $clog2(BUFFER_LENGTH + 1) : 8;
  localparam logic [PosW-1:0] BufLen  = PosW'(BUFFER_LENGTH);
  localparam logic [PosW-1:0] LastPos = PosW'(BUFFER_LENGTH - 1);

  typedef enum logic [3:0] {
    StIdle  = 4'b0001,
    StSkip  = 4'b0010,
    StSign  = 4'b0100,
    StDigit = 4'b1000
  } emit_state_e;

  emit_state_e state_q, state_d;
  logic [BcdW-1:0]    bcd_q, bcd_d;
  logic [DigCntW-1:0] ndig_q, ndig_d;
  logic [PosW-1:0]    pos_q, pos_d, pos_inc;
  logic [7:0]         end_q, end_d;
  logic               neg_q, neg_d;
  logic               sign_en_q, sign_en_d;
  logic [6:0]         start_q, start_d;
  logic               out_valid_q, out_valid_d;
  s2d_out_t           out_q, out_d;
  logic               adv, skip_done, pos_done;
  logic [3:0]         top_digit;

  assign top_digit = bcd_q[BcdW-1 -: 4];
  assign skip_done = (top_digit != 4'd0) || (ndig_q == DigCntW'(1));
  assign pos_done  = (pos_q < BufLen);
  assign pos_inc   = (pos_q == LastPos) ? '0 : pos_q + PosW'(1);
  assign adv       = !out_valid_q || out_ready_i;

  always_comb begin
    state_d     = state_q;
    bcd_d       = bcd_q;
    ndig_d      = ndig_q;
    pos_d       = pos_q;
    end_d       = end_q;
    neg_d       = neg_q;
    sign_en_d   = sign_en_q;
    start_d     = start_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      StIdle: begin
        if (work_valid_i) begin
          bcd_d     = work_i.bcd;
          neg_d     = work_i.negative;
          sign_en_d = work_i.sign_en;
          start_d   = work_i.start_position;
          pos_d     = PosW'(work_i.start_position);
          ndig_d    = DigCntW'(NumDigits);
          state_d   = StSkip;
        end
      end
      StSkip: begin
        // Leading zeros are dropped and the start position reduced into the buffer.
        if (!skip_done) begin
          bcd_d  = {bcd_q[BcdW-5:0], 4'd0};
          ndig_d = ndig_q - DigCntW'(1);
        end
        if (!pos_done) begin
          pos_d = pos_q - BufLen;
        end
        if (skip_done && pos_done) begin
          end_d   = 8'(start_q) + 8'(ndig_q) + 8'(sign_en_q);
          state_d = sign_en_q ? StSign : StDigit;
        end
      end
      StSign: begin
        if (adv) begin
          out_d.char_code     = neg_q ? CharMinus : CharPlus;
          out_d.char_position = pos_q[6:0];
          out_d.end_position  = end_q;
          out_d.is_last       = 1'b0;
          out_valid_d         = 1'b1;
          pos_d               = pos_inc;
          state_d             = StDigit;
        end
      end
      StDigit: begin
        if (adv) begin
          out_d.char_code     = CharZero + {3'd0, top_digit};
          out_d.char_position = pos_q[6:0];
          out_d.end_position  = end_q;
          out_d.is_last       = (ndig_q == DigCntW'(1));
          out_valid_d         = 1'b1;
          pos_d               = pos_inc;
          bcd_d               = {bcd_q[BcdW-5:0], 4'd0};
          ndig_d              = ndig_q - DigCntW'(1);
          if (ndig_q == DigCntW'(1)) begin
            state_d = StIdle;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
      ndig_q      <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      ndig_q      <= ndig_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bcd_q     <= bcd_d;
    pos_q     <= pos_d;
    end_q     <= end_d;
    neg_q     <= neg_d;
    sign_en_q <= sign_en_d;
    start_q   <= start_d;
    out_q     <= out_d;
  end

  assign work_ready_o = (state_q == StIdle);
  assign out_valid_o  = out_valid_q;
  assign out_o        = out_q;

endmodule

`default_nettype wire

// File: hw/rtl/signed_int_to_decimal_ascii_top.sv
// Top level of the signed 32-bit integer to decimal ASCII text converter.
`default_nettype none

// Each input beat carries a signed 32-bit value, a buffer start position and a
// flag asking for a plus sign on values that are not negative. The block answers
// with one output beat per character: an optional sign, then the decimal digits
// with the most significant first and no leading zeros, zero giving a single
// '0'. Every beat carries its buffer position, wrapped at BUFFER_LENGTH and
// shown in seven bits, and the end position (start plus the characters
// written); the final character of a run is marked with is_last. The most
// negative value is converted through its unsigned magnitude. Conversion is
// bit-serial: after a value is taken, a shift-and-add-three unit works through
// its magnitude one bit at a time and then holds the digits until the emitter
// takes them. The emitter drops leading zero digits one at a time (up to nine)
// while it reduces the start position into the buffer by subtracting the
// BUFFER_LENGTH, one subtraction per cycle; it then settles the end position
// and sends the sign and digit beats while the output side accepts. A new
// value is taken the cycle after the converter has handed its previous result
// on, so conversion of one value overlaps emission of the one before; the
// throughput is set by the serial converter (take, one shift per magnitude
// bit, hand-over), as long as the output side accepts characters promptly.
module signed_int_to_decimal_ascii_top #(
  parameter int unsigned BUFFER_LENGTH = 128
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire s2d_pkg::s2d_in_t   in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output s2d_pkg::s2d_out_t       out_data_o
);
  import s2d_pkg::*;

  logic      work_valid;
  logic      work_ready;
  s2d_work_t work;

  // Serial converter: magnitude into ten BCD digits.
  s2d_dabble u_dabble (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .work_valid_o (work_valid),
    .work_ready_i (work_ready),
    .work_o       (work)
  );

  // Emitter: leading-zero removal, sign and digit beats with an output register.
  s2d_emit #(
    .BUFFER_LENGTH (BUFFER_LENGTH)
  ) u_emit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .work_valid_i (work_valid),
    .work_ready_o (work_ready),
    .work_i       (work),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_o        (out_data_o)
  );

  // The converter is busy for the cycle after it takes a value.
  a_busy_after_accept: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o
  ) else $error("converter took a value while still converting the previous one");

  // Only signs and decimal digits are ever presented.
  a_char_legal: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.char_code == CharMinus ||
                     out_data_o.char_code == CharPlus ||
                     (out_data_o.char_code >= CharZero &&
                      out_data_o.char_code <= CharZero + 7'd9))
  ) else $error("illegal character code on the output");

  // A sign is always followed by at least one digit.
  a_sign_not_last: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.char_code == CharMinus ||
                     out_data_o.char_code == CharPlus)) |-> !out_data_o.is_last
  ) else $error("sign character marked as the last of its run");

  // After taking a converted value the emitter is no longer free.
  a_handover: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (work_valid && work_ready) |=> !work_ready
  ) else $error("emitter still free after taking a converted value");

endmodule

`default_nettype wire
